FILE: src/wnm_pkg.sv
// Shared types, constants and helpers for the wildcard name matcher.
// No dependencies; imported by every module of the block.
package wnm_pkg;

    localparam int PatternMax = 16;
    localparam int PatChars   = 16;
    localparam int PosW       = 5;
    localparam int CharW      = 8;
    localparam int CfgIdxW    = 2;
    localparam int CfgDataW   = 64;

    typedef logic [PosW-1:0]  pos_t;
    typedef logic [CharW-1:0] char_t;

    localparam char_t CH_ANY   = 8'h3F;
    localparam char_t CH_STAR  = 8'h2A;
    localparam char_t CH_NOT   = 8'h21;
    localparam char_t CH_OPEN  = 8'h5B;
    localparam char_t CH_CLOSE = 8'h5D;

    localparam char_t CH_LOWER_A = 8'h61;
    localparam char_t CH_LOWER_Z = 8'h7A;
    localparam char_t CASE_BIT   = 8'h20;

    typedef enum logic [CfgIdxW-1:0] {
        REG_PAT_LOW  = 2'd0,
        REG_PAT_HIGH = 2'd1,
        REG_PAT_LEN  = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_NOT,
        ST_SCAN1,
        ST_SCAN2,
        ST_TERM
    } state_t;

    typedef struct packed {
        logic valid;
        logic skip;
        logic at_end;
        logic eq;
        logic is_any;
        logic is_star;
        logic is_not;
        logic is_open;
        logic is_close;
        logic out_full;
    } dp_status_t;

    typedef struct packed {
        logic load_char;
        logic use_scan;
        logic pos_inc;
        logic pos_end;
        logic pos_from_scan;
        logic scan_from_pos;
        logic scan_inc;
        logic clear_valid;
        logic set_skip;
        logic clr_skip;
        logic clear_match;
        logic load_out;
        logic match_bit;
    } dp_cmd_t;

    function automatic char_t fold(input char_t c);
        char_t r;
        r = c;
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            r = c - CASE_BIT;
        end
        return r;
    endfunction

endpackage

FILE: src/wildcard_name_matcher.sv
// Top level of the wildcard name matcher: stream ports, config port, assertions.
// Depends on wnm_pkg, wnm_ctrl and wnm_datapath.
// A character word steps across any stars crossed, a '!', and the set characters
// walked up to the closing ']' or pattern end; one word at a time, none taken while
// a result waits unread. A terminator steps across any trailing stars; matched
// shows in the output register the cycle after its last step. Reset (aresetn low,
// synchronous) clears pattern, match state and output.
module wildcard_name_matcher (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [wnm_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [wnm_pkg::CfgDataW-1:0]  cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] name_char
    input  logic                          s_tlast,   // end_of_name
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata    // [0] matched, [7:1] zero
);
    import wnm_pkg::*;

    dp_status_t status;
    dp_cmd_t    cmd;
    state_t     state;
    logic       matched;

    assign cfg_ready = 1'b1;

    wnm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd),
        .state    (state)
    );

    wnm_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_char    (s_tdata[CharW-1:0]),
        .cmd       (cmd),
        .m_tready  (m_tready),
        .status    (status),
        .m_valid   (m_tvalid),
        .m_matched (matched)
    );

    assign m_tdata = {7'b0, matched};

    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state == ST_IDLE)
        else $error("input ready outside idle");

    a_term_frees_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !m_tvalid && state == ST_TERM)
        else $error("terminator accepted while result pending");

    a_result_from_term: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && $past(aresetn) && $rose(m_tvalid)) |-> $past(state == ST_TERM))
        else $error("result raised outside terminator handling");

endmodule

FILE: src/wnm_datapath.sv
// Datapath: pattern registers, match state, scan pointer, result register.
// Depends on wnm_pkg; driven by commands from wnm_ctrl.
module wnm_datapath (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    input  logic [wnm_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [wnm_pkg::CfgDataW-1:0] cfg_data,
    input  wnm_pkg::char_t          s_char,
    input  wnm_pkg::dp_cmd_t        cmd,
    input  logic                    m_tready,
    output wnm_pkg::dp_status_t     status,
    output logic                    m_valid,
    output logic                    m_matched
);
    import wnm_pkg::*;

    localparam pos_t EndCap = pos_t'((PatternMax < PatChars) ? PatternMax : PatChars);

    logic [CfgDataW-1:0] pat_low_reg, pat_low_next;
    logic [CfgDataW-1:0] pat_high_reg, pat_high_next;
    pos_t                len_reg, len_next;
    pos_t                pos_reg, pos_next;
    pos_t                scan_reg, scan_next;
    logic                valid_reg, valid_next;
    logic                skip_reg, skip_next;
    char_t               u_reg, u_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_bit_reg, out_bit_next;

    logic [2*CfgDataW-1:0] pat_all;
    pos_t                  pat_end;
    pos_t                  sel;
    char_t                 pc;

    assign pat_all = {pat_high_reg, pat_low_reg};
    assign pat_end = (len_reg > EndCap) ? EndCap : len_reg;
    assign sel     = cmd.use_scan ? scan_reg : pos_reg;
    assign pc      = pat_all[{sel[3:0], 3'b000} +: CharW];

    always_comb begin
        status.valid    = valid_reg;
        status.skip     = skip_reg;
        status.at_end   = (sel >= pat_end);
        status.eq       = (fold(pc) == u_reg);
        status.is_any   = (pc == CH_ANY);
        status.is_star  = (pc == CH_STAR);
        status.is_not   = (pc == CH_NOT);
        status.is_open  = (pc == CH_OPEN);
        status.is_close = (pc == CH_CLOSE);
        status.out_full = out_valid_reg;
    end

    always_comb begin
        pat_low_next  = pat_low_reg;
        pat_high_next = pat_high_reg;
        len_next      = len_reg;
        if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PAT_LOW:  pat_low_next  = cfg_data;
                REG_PAT_HIGH: pat_high_next = cfg_data;
                REG_PAT_LEN:  len_next      = cfg_data[PosW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        priority if (cmd.clear_match) begin
            pos_next = '0;
        end else if (cmd.pos_end) begin
            pos_next = pat_end;
        end else if (cmd.pos_from_scan) begin
            pos_next = scan_reg + pos_t'(1);
        end else if (cmd.pos_inc) begin
            pos_next = pos_reg + pos_t'(1);
        end else begin
            pos_next = pos_reg;
        end

        priority if (cmd.scan_from_pos) begin
            scan_next = pos_reg + pos_t'(1);
        end else if (cmd.scan_inc) begin
            scan_next = scan_reg + pos_t'(1);
        end else begin
            scan_next = scan_reg;
        end

        priority if (cmd.clear_match) begin
            valid_next = 1'b1;
        end else if (cmd.clear_valid) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end

        priority if (cmd.clear_match) begin
            skip_next = 1'b0;
        end else if (cmd.set_skip) begin
            skip_next = 1'b1;
        end else if (cmd.clr_skip) begin
            skip_next = 1'b0;
        end else begin
            skip_next = skip_reg;
        end

        u_next = cmd.load_char ? fold(s_char) : u_reg;

        out_valid_next = out_valid_reg;
        out_bit_next   = out_bit_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
            out_bit_next   = cmd.match_bit;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg   <= '0;
            pat_high_reg  <= '0;
            len_reg       <= '0;
            pos_reg       <= '0;
            valid_reg     <= 1'b1;
            skip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            pat_low_reg   <= pat_low_next;
            pat_high_reg  <= pat_high_next;
            len_reg       <= len_next;
            pos_reg       <= pos_next;
            valid_reg     <= valid_next;
            skip_reg      <= skip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg    <= scan_next;
        u_reg       <= u_next;
        out_bit_reg <= out_bit_next;
    end

    assign m_valid   = out_valid_reg;
    assign m_matched = out_bit_reg;

endmodule

FILE: src/wnm_ctrl.sv
// Controller state machine: sequences one name character or terminator word.
// Depends on wnm_pkg; commands wnm_datapath and reads its status.
module wnm_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tlast,
    input  logic                m_tready,
    input  wnm_pkg::dp_status_t status,
    output logic                s_tready,
    output wnm_pkg::dp_cmd_t    cmd,
    output wnm_pkg::state_t     state
);
    import wnm_pkg::*;

    state_t state_reg, state_next;
    logic   in_ready;
    logic   skip_stop;

    assign in_ready  = (state_reg == ST_IDLE) && (!status.out_full || m_tready);
    assign skip_stop = status.skip && (status.at_end || !status.eq);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && in_ready) begin
                    state_next = s_tlast ? ST_TERM : ST_STEP;
                end
            end
            ST_STEP: begin
                priority if (!status.valid || skip_stop || status.at_end) begin
                    state_next = ST_IDLE;
                end else if (status.is_star) begin
                    state_next = ST_STEP;
                end else if (status.is_not) begin
                    state_next = ST_NOT;
                end else if (status.is_open) begin
                    state_next = ST_SCAN1;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_NOT: begin
                state_next = ST_IDLE;
            end
            ST_SCAN1: begin
                priority if (status.at_end || status.is_close) begin
                    state_next = ST_IDLE;
                end else if (status.eq) begin
                    state_next = ST_SCAN2;
                end else begin
                    state_next = ST_SCAN1;
                end
            end
            ST_SCAN2: begin
                if (status.at_end || status.is_close) begin
                    state_next = ST_IDLE;
                end
            end
            ST_TERM: begin
                if (!(status.valid && !status.at_end && status.is_star)) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready      = in_ready;
                cmd.load_char = s_tvalid && in_ready && !s_tlast;
            end
            ST_STEP: begin
                if (status.valid && !skip_stop) begin
                    cmd.clr_skip = status.skip;
                    priority if (status.at_end) begin
                        cmd.clear_valid = 1'b1;
                    end else if (status.is_any) begin
                        cmd.pos_inc = 1'b1;
                    end else if (status.is_star) begin
                        cmd.pos_inc  = 1'b1;
                        cmd.set_skip = 1'b1;
                    end else if (status.is_not || status.is_open) begin
                        cmd.scan_from_pos = 1'b1;
                    end else begin
                        cmd.pos_inc     = 1'b1;
                        cmd.clear_valid = !status.eq;
                    end
                end
            end
            ST_NOT: begin
                cmd.use_scan = 1'b1;
                priority if (status.at_end) begin
                    cmd.pos_end = 1'b1;
                end else if (!status.eq) begin
                    cmd.pos_from_scan = 1'b1;
                end else begin
                    cmd.clear_valid = 1'b1;
                end
            end
            ST_SCAN1: begin
                cmd.use_scan = 1'b1;
                if (status.at_end || status.is_close) begin
                    cmd.clear_valid = 1'b1;
                end else begin
                    cmd.scan_inc = 1'b1;
                end
            end
            ST_SCAN2: begin
                cmd.use_scan = 1'b1;
                priority if (status.at_end) begin
                    cmd.pos_end = 1'b1;
                end else if (status.is_close) begin
                    cmd.pos_from_scan = 1'b1;
                end else begin
                    cmd.scan_inc = 1'b1;
                end
            end
            ST_TERM: begin
                if (status.valid && !status.at_end && status.is_star) begin
                    cmd.pos_inc = 1'b1;
                end else begin
                    cmd.load_out    = 1'b1;
                    cmd.match_bit   = status.valid && status.at_end;
                    cmd.clear_match = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

FILE: tb/wildcard_name_matcher_tb.sv
// Testbench for wildcard_name_matcher: streams file names against configured patterns
// and checks each matched word against an in-bench match predictor.
// Depends on wnm_pkg and the wildcard_name_matcher RTL.
module wildcard_name_matcher_tb;
    import wnm_pkg::*;

    localparam int QuietLimit = 5000;
    localparam int IdleTail   = 48;
    localparam int HoldCycles = 400;
    localparam int NameWords  = 625;

    class name_match_scoreboard;
        logic [63:0] pat_lo  = '0;
        logic [63:0] pat_hi  = '0;
        logic [4:0]  pat_len = '0;
        pos_t        match_pos = '0;
        bit          name_ok   = 1'b1;
        bit          star_skip = 1'b0;
        bit          matched_q[$];
        int          errors = 0;

        function char_t upcase(char_t c);
            if (c >= 8'h61 && c <= 8'h7A) begin
                return c - 8'h20;
            end
            return c;
        endfunction

        function int pat_stop();
            int e;
            e = pat_len;
            if (e > PatChars) e = PatChars;
            if (e > PatternMax) e = PatternMax;
            return e;
        endfunction

        function char_t pat_char(int idx);
            int i;
            i = idx & 15;
            if (i < 8) return pat_lo[(i % 8) * 8 +: 8];
            return pat_hi[(i % 8) * 8 +: 8];
        endfunction

        function void write_reg(cfg_reg_t idx, logic [63:0] d);
            case (idx)
                REG_PAT_LOW:  pat_lo  = d;
                REG_PAT_HIGH: pat_hi  = d;
                REG_PAT_LEN:  pat_len = d[4:0];
                default: ;
            endcase
        endfunction

        function void take_name_char(char_t c);
            int    stop;
            int    p;
            int    q;
            char_t u;
            stop = pat_stop();
            u    = upcase(c);
            forever begin
                if (!name_ok) return;
                p = match_pos;
                if (star_skip) begin
                    if (p >= stop || upcase(pat_char(p)) != u) return;
                    star_skip = 1'b0;
                end
                if (p >= stop) begin
                    name_ok = 1'b0;
                    return;
                end
                case (pat_char(p))
                    CH_ANY: begin
                        match_pos = pos_t'(p + 1);
                        return;
                    end
                    CH_STAR: begin
                        match_pos = pos_t'(p + 1);
                        star_skip = 1'b1;
                    end
                    CH_NOT: begin
                        if (p + 1 >= stop) begin
                            match_pos = pos_t'(stop);
                        end else if (u != upcase(pat_char(p + 1))) begin
                            match_pos = pos_t'(p + 2);
                        end else begin
                            name_ok = 1'b0;
                        end
                        return;
                    end
                    CH_OPEN: begin
                        q = p + 1;
                        while (q < stop && pat_char(q) != CH_CLOSE && upcase(pat_char(q)) != u)
                            q++;
                        if (q >= stop || pat_char(q) == CH_CLOSE) begin
                            name_ok = 1'b0;
                            return;
                        end
                        q++;
                        while (q < stop && pat_char(q) != CH_CLOSE)
                            q++;
                        match_pos = pos_t'((q < stop) ? q + 1 : stop);
                        return;
                    end
                    default: begin
                        if (upcase(pat_char(p)) != u) name_ok = 1'b0;
                        match_pos = pos_t'(p + 1);
                        return;
                    end
                endcase
            end
        endfunction

        function void note_word(char_t c, bit last);
            int stop;
            int p;
            if (!last) begin
                take_name_char(c);
                return;
            end
            stop = pat_stop();
            p    = match_pos;
            if (name_ok) begin
                while (p < stop && pat_char(p) == CH_STAR)
                    p++;
            end
            matched_q.push_back(name_ok && p >= stop);
            match_pos = '0;
            name_ok   = 1'b1;
            star_skip = 1'b0;
        endfunction

        function void report(string what, logic [7:0] expd, logic [7:0] got);
            errors++;
            if (errors <= 10)
                $display("%t mismatch: %s, expected %02h got %02h", $realtime, what, expd, got);
        endfunction

        function void check_result(logic [7:0] d);
            bit expv;
            if (matched_q.size() == 0) begin
                report("word with no name pending", 8'h00, d);
                return;
            end
            expv = matched_q.pop_front();
            if (d !== {7'd0, expv})
                report("matched", {7'd0, expv}, d);
        endfunction

        function int pending();
            return matched_q.size();
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [7:0]          m_tdata;

    name_match_scoreboard sb;

    bit    tx_gaps  = 1'b1;
    bit    rx_gaps  = 1'b1;
    bit    hold_req = 1'b0;
    int    words_sent = 0;
    int    pat_len_now = 0;
    char_t pat_buf[16];
    char_t name_buf[$];

    wildcard_name_matcher i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic char_t rand_byte();
        return char_t'($urandom_range(0, 255));
    endfunction

    function automatic char_t rand_letter();
        return char_t'($urandom_range(65, 90)) | ($urandom_range(0, 1) ? 8'h20 : 8'h00);
    endfunction

    function automatic char_t flip_case(char_t c);
        if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) && $urandom_range(0, 1))
            return c ^ 8'h20;
        return c;
    endfunction

    function automatic logic [127:0] pack_text(string s);
        logic [127:0] r;
        r = '0;
        for (int i = 0; i < s.len() && i < 16; i++)
            r[i*8 +: 8] = s[i];
        return r;
    endfunction

    task automatic send_word(char_t c, bit last);
        while (tx_gaps && $urandom_range(0, 99) < 24) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_word(c, last);
        words_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], 1'b0);
        send_word(rand_byte(), 1'b1);
    endtask

    task automatic send_name_buf();
        foreach (name_buf[i])
            send_word(name_buf[i], 1'b0);
        send_word(rand_byte(), 1'b1);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [63:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, d);
    endtask

    task automatic load_pattern(logic [63:0] lo, logic [63:0] hi, logic [4:0] len,
                                logic [2:0] mask);
        if (mask[0]) write_reg(REG_PAT_LOW, lo);
        if (mask[1]) write_reg(REG_PAT_HIGH, hi);
        if (mask[2]) begin
            write_reg(REG_PAT_LEN, {59'd0, len});
            pat_len_now = len;
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (IdleTail) @(posedge aclk);
    endtask

    task automatic make_pattern();
        char_t q[$];
        int    target;
        int    n;
        for (int i = 0; i < 16; i++)
            pat_buf[i] = rand_byte();
        target = $urandom_range(1, 16);
        while (q.size() < target) begin
            case ($urandom_range(0, 11))
                0, 1, 2: q.push_back(rand_letter());
                3:       q.push_back(rand_byte());
                4, 5:    q.push_back(CH_ANY);
                6, 7:    q.push_back(CH_STAR);
                8: begin
                    q.push_back(CH_NOT);
                    if ($urandom_range(0, 3) != 0) q.push_back(rand_letter());
                end
                9, 10: begin
                    q.push_back(CH_OPEN);
                    n = $urandom_range(0, 3);
                    repeat (n) q.push_back(rand_letter());
                    if ($urandom_range(0, 4) != 0) q.push_back(CH_CLOSE);
                end
                default: q.push_back(8'h00);
            endcase
        end
        for (int i = 0; i < q.size() && i < 16; i++)
            pat_buf[i] = q[i];
        n = (q.size() > 16) ? 16 : q.size();
        case ($urandom_range(0, 9))
            0:       pat_len_now = 0;
            1:       pat_len_now = $urandom_range(17, 31);
            2:       pat_len_now = 16;
            default: pat_len_now = n;
        endcase
    endtask

    // mostly names built to walk the pattern, some mutated, some plain noise
    task automatic make_name();
        int    p;
        int    q;
        int    n;
        int    stop;
        char_t c;
        name_buf.delete();
        stop = (pat_len_now > 16) ? 16 : pat_len_now;
        p = 0;
        while (p < stop) begin
            c = pat_buf[p];
            if (c == CH_ANY) begin
                name_buf.push_back(rand_letter());
                p++;
            end else if (c == CH_STAR) begin
                n = $urandom_range(0, 2);
                repeat (n) name_buf.push_back(rand_letter());
                p++;
            end else if (c == CH_NOT) begin
                if (p + 1 >= stop) begin
                    name_buf.push_back(rand_byte());
                    p = stop;
                end else begin
                    c = rand_letter();
                    if (sb.upcase(c) == sb.upcase(pat_buf[p+1])) c = c ^ 8'h01;
                    name_buf.push_back(c);
                    p += 2;
                end
            end else if (c == CH_OPEN) begin
                q = p + 1;
                while (q < stop && pat_buf[q] != CH_CLOSE) q++;
                if (q == p + 1) name_buf.push_back(rand_letter());
                else name_buf.push_back(flip_case(pat_buf[$urandom_range(p + 1, q - 1)]));
                p = (q < stop) ? q + 1 : stop;
            end else begin
                name_buf.push_back(flip_case(c));
                p++;
            end
        end
        if ($urandom_range(0, 99) < 25) begin
            n = $urandom_range(0, 2);
            if (n == 0 || name_buf.size() == 0)
                name_buf.insert($urandom_range(0, name_buf.size()), rand_byte());
            else if (n == 1)
                name_buf[$urandom_range(0, name_buf.size() - 1)] = rand_byte();
            else
                name_buf.delete($urandom_range(0, name_buf.size() - 1));
        end
        if ($urandom_range(0, 99) < 15) begin
            name_buf.delete();
            n = $urandom_range(0, 8);
            repeat (n) name_buf.push_back(rand_byte());
        end
    endtask

    // receiver: random back-pressure plus one long hold-off on request
    initial begin : rx_side
        int hold_left;
        bit hold_served;
        hold_left   = 0;
        hold_served = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (hold_req && !hold_served) begin
                hold_served = 1'b1;
                hold_left   = HoldCycles;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !(rx_gaps && $urandom_range(0, 99) < 24);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QuietLimit) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        logic [127:0] txt;
        logic [63:0]  lo;
        logic [63:0]  hi;
        int           ph;
        int           n_names;
        sb = new;
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_PAT_LOW;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty pattern out of reset; zero byte is an ordinary char
        send_text("");
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b1);
        wait_idle();

        txt = pack_text("a?!B[cD]*");
        load_pattern(txt[63:0], txt[127:64], 5'd9, 3'b111);
        send_text("AzqC");
        send_text("AzBC");
        wait_idle();

        // zero byte literal then dangling '!'
        load_pattern(64'h2100, 64'h0, 5'd2, 3'b111);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b1);
        wait_idle();

        // unclosed set
        txt = pack_text("[ab");
        load_pattern(txt[63:0], txt[127:64], 5'd3, 3'b111);
        send_text("B");
        send_text("c");
        wait_idle();

        // empty set
        txt = pack_text("[]");
        load_pattern(txt[63:0], txt[127:64], 5'd2, 3'b111);
        send_text("x");
        wait_idle();

        // length beyond 16 clamps; last char is the only non-star
        load_pattern({8{CH_STAR}}, {8'h5A, {7{CH_STAR}}}, 5'd31, 3'b111);
        send_text("Z");
        wait_idle();

        ph = 0;
        while (words_sent < NameWords) begin
            tx_gaps = (ph < 5 || ph > 8);
            rx_gaps = (ph < 5 || ph > 8);
            make_pattern();
            for (int i = 0; i < 8; i++) begin
                lo[i*8 +: 8] = pat_buf[i];
                hi[i*8 +: 8] = pat_buf[i+8];
            end
            load_pattern(lo, hi, pat_len_now[4:0],
                         (ph == 0) ? 3'b111 : 3'($urandom_range(1, 7)));
            if (ph == 3) hold_req = 1'b1;
            n_names = (ph == 3) ? 12 : $urandom_range(3, 10);
            repeat (n_names) begin
                make_name();
                send_name_buf();
            end
            wait_idle();
            ph++;
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: files.f
src/wnm_pkg.sv
src/wnm_datapath.sv
src/wnm_ctrl.sv
src/wildcard_name_matcher.sv
tb/wildcard_name_matcher_tb.sv
